// ----- hw/rtl/residual_and_r_squared_accumulator_assert.svh -----
// Assertion macros used by the checker file of the accumulator.
`ifndef RESIDUAL_AND_R_SQUARED_ACCUMULATOR_ASSERT_SVH
`define RESIDUAL_AND_R_SQUARED_ACCUMULATOR_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define RSQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define RSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/rsq_acc_pkg.sv -----
// Package with shared types, widths and codes of the residual and R squared accumulator.
package rsq_acc_pkg;

  localparam int MAX_ITEMS_DEF     = 1024;
  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int RSQ_FRAC_BITS_DEF = 16;

  // Port widths.
  localparam int IN_W    = 24;
  localparam int CHI_W   = 60;
  localparam int RSQ_W   = 17;
  localparam int CNT_W   = 11;

  // Internal widths.
  localparam int XW      = 25;   // sign-extended sample and difference
  localparam int SUM1_W  = 34;   // first-order sums
  localparam int SUM2_W  = 58;   // second-order sums
  localparam int MW      = 72;   // serial multiplier operand
  localparam int PW      = 2 * MW;
  localparam int DW      = 160;  // divider remainder and divisor
  localparam int STEP_W  = $clog2(MW);

  typedef enum logic [6:0] {
    S_ACC    = 7'b0000001,
    S_MLOAD  = 7'b0000010,
    S_MRUN   = 7'b0000100,
    S_MSTORE = 7'b0001000,
    S_CHK    = 7'b0010000,
    S_DRUN   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    OP_N_XY  = 3'd0,
    OP_X_Y   = 3'd1,
    OP_N_XX  = 3'd2,
    OP_X_X   = 3'd3,
    OP_N_YY  = 3'd4,
    OP_Y_Y   = 3'd5,
    OP_A_A   = 3'd6,
    OP_VX_VY = 3'd7
  } mul_op_t;

  typedef struct packed {
    logic    acc_en;
    logic    mul_load;
    logic    mul_step;
    logic    mul_store;
    logic    div_step;
    logic    out_load;
    mul_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic degen;
  } dp_status_t;

endpackage

// ----- hw/rtl/residual_and_r_squared_accumulator.sv -----
// Top level of the residual and R squared accumulator.
//
// Input channel (in_valid/in_ready): one beat per pair of signed Q12.12 target and
// model samples; in_last_item closes the run. Beats are taken one per cycle while
// the block accumulates. Pairs past MAX_ITEMS are dropped and flag out_overflowed.
// After the last beat in_ready drops while the result is computed by one shared
// shift-add multiplier (8 products of MW=72 steps each) and a restoring divider of
// RSQ_FRAC_BITS+2 steps; only 6 products run, and no divide, when a variance is
// zero (degenerate).
// Output channel (out_valid/out_ready): one result beat per run, held in an output
// register. While it waits for the receiver, the block already takes the next run;
// a further result waits until the held beat is taken.
// Reset (rst_n, synchronous, active low) clears the sums, count and flags and
// leaves no result pending.
module residual_and_r_squared_accumulator #(
  parameter int MAX_ITEMS     = rsq_acc_pkg::MAX_ITEMS_DEF,
  parameter int SAMPLE_BITS   = rsq_acc_pkg::SAMPLE_BITS_DEF,
  parameter int RSQ_FRAC_BITS = rsq_acc_pkg::RSQ_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rsq_acc_pkg::IN_W-1:0]  in_target_value,
  input  logic signed [rsq_acc_pkg::IN_W-1:0]  in_model_value,
  input  logic                                in_last_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rsq_acc_pkg::CHI_W-1:0]       out_chi_square,
  output logic [rsq_acc_pkg::RSQ_W-1:0]       out_r_squared,
  output logic [rsq_acc_pkg::CNT_W-1:0]       out_pair_count,
  output logic                                out_degenerate,
  output logic                                out_overflowed
);
  import rsq_acc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rsq_acc_ctrl #(
    .RSQ_FRAC_BITS(RSQ_FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last_item),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rsq_acc_dp #(
    .MAX_ITEMS    (MAX_ITEMS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .RSQ_FRAC_BITS(RSQ_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_target_value (in_target_value),
    .in_model_value  (in_model_value),
    .out_chi_square  (out_chi_square),
    .out_r_squared   (out_r_squared),
    .out_pair_count  (out_pair_count),
    .out_degenerate  (out_degenerate),
    .out_overflowed  (out_overflowed)
  );

endmodule

// ----- hw/rtl/rsq_acc_ctrl.sv -----
// Controller state machine sequencing accumulation, the multiply chain and the divide.
module rsq_acc_ctrl #(
  parameter int RSQ_FRAC_BITS = rsq_acc_pkg::RSQ_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_last,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  rsq_acc_pkg::dp_status_t status,
  output rsq_acc_pkg::dp_cmd_t    cmd
);
  import rsq_acc_pkg::*;

  localparam int QW = RSQ_FRAC_BITS + 2;

  state_t            state_r, state_nxt;
  mul_op_t           op_r, op_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    cnt_nxt      = cnt_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.op       = op_r;
    unique case (state_r)
      S_ACC: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc_en = 1'b1;
          if (in_last) begin
            state_nxt = S_MLOAD;
            op_nxt    = OP_N_XY;
          end
        end
      end
      S_MLOAD: begin
        cmd.mul_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_MRUN;
      end
      S_MRUN: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(MW - 1)) begin
          state_nxt = S_MSTORE;
        end
      end
      S_MSTORE: begin
        cmd.mul_store = 1'b1;
        if (op_r == OP_VX_VY) begin
          cnt_nxt   = '0;
          state_nxt = S_DRUN;
        end else if (op_r == OP_Y_Y) begin
          state_nxt = S_CHK;
        end else begin
          op_nxt    = mul_op_t'(op_r + 3'd1);
          state_nxt = S_MLOAD;
        end
      end
      S_CHK: begin
        if (status.degen) begin
          state_nxt = S_OUT;
        end else begin
          op_nxt    = OP_A_A;
          state_nxt = S_MLOAD;
        end
      end
      S_DRUN: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(QW - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  // Hold a result beat until taken.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      op_r        <= OP_N_XY;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/rsq_acc_dp.sv -----
// Datapath: running sums, shared serial multiplier, restoring divider and result registers.
module rsq_acc_dp #(
  parameter int MAX_ITEMS     = rsq_acc_pkg::MAX_ITEMS_DEF,
  parameter int SAMPLE_BITS   = rsq_acc_pkg::SAMPLE_BITS_DEF,
  parameter int RSQ_FRAC_BITS = rsq_acc_pkg::RSQ_FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  rsq_acc_pkg::dp_cmd_t                     cmd,
  output rsq_acc_pkg::dp_status_t                  status,
  input  logic signed [rsq_acc_pkg::IN_W-1:0]      in_target_value,
  input  logic signed [rsq_acc_pkg::IN_W-1:0]      in_model_value,
  output logic        [rsq_acc_pkg::CHI_W-1:0]     out_chi_square,
  output logic        [rsq_acc_pkg::RSQ_W-1:0]     out_r_squared,
  output logic        [rsq_acc_pkg::CNT_W-1:0]     out_pair_count,
  output logic                                    out_degenerate,
  output logic                                    out_overflowed
);
  import rsq_acc_pkg::*;

  localparam int QW = RSQ_FRAC_BITS + 2;
  localparam logic [QW-1:0] QONE = QW'(1) << RSQ_FRAC_BITS;

  // Run state.
  logic        [CNT_W-1:0]  cnt_r;
  logic signed [SUM1_W-1:0] sum_t_r, sum_m_r;
  logic signed [SUM2_W-1:0] sum_xy_r;
  logic        [SUM2_W-1:0] sum_tsq_r, sum_msq_r;
  logic        [CHI_W-1:0]  sum_dsq_r;
  logic                     ovf_r;

  // Per-beat sample terms.
  logic signed [SAMPLE_BITS-1:0] xs, ys;
  logic signed [XW-1:0]          x, y, d;
  logic signed [2*XW-1:0]        xx, yy, xy, dd;
  logic                          full;

  assign xs   = in_target_value[SAMPLE_BITS-1:0];
  assign ys   = in_model_value[SAMPLE_BITS-1:0];
  assign x    = XW'(xs);
  assign y    = XW'(ys);
  assign d    = y - x;
  assign xx   = x * x;
  assign yy   = y * y;
  assign xy   = x * y;
  assign dd   = d * d;
  assign full = (cnt_r == CNT_W'(MAX_ITEMS));

  // Accumulate a beat; clear on reset and when the result loads.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      cnt_r     <= '0;
      sum_t_r   <= '0;
      sum_m_r   <= '0;
      sum_xy_r  <= '0;
      sum_tsq_r <= '0;
      sum_msq_r <= '0;
      sum_dsq_r <= '0;
      ovf_r     <= 1'b0;
    end else if (cmd.acc_en) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r     <= cnt_r + 1'b1;
        sum_t_r   <= sum_t_r + SUM1_W'(x);
        sum_m_r   <= sum_m_r + SUM1_W'(y);
        sum_xy_r  <= sum_xy_r + SUM2_W'(xy);
        sum_tsq_r <= sum_tsq_r + SUM2_W'(xx);
        sum_msq_r <= sum_msq_r + SUM2_W'(yy);
        sum_dsq_r <= sum_dsq_r + CHI_W'(dd);
      end
    end
  end

  // Serial multiplier: operand select.
  logic signed [MW-1:0] op_a, op_b;
  logic        [MW-1:0] abs_a, abs_b;
  logic signed [MW-1:0] pa_r, a_r, vx_r, vy_r;

  always_comb begin
    unique case (cmd.op)
      OP_N_XY:  begin op_a = MW'(cnt_r);   op_b = MW'(sum_xy_r);  end
      OP_X_Y:   begin op_a = MW'(sum_t_r); op_b = MW'(sum_m_r);   end
      OP_N_XX:  begin op_a = MW'(cnt_r);   op_b = MW'(sum_tsq_r); end
      OP_X_X:   begin op_a = MW'(sum_t_r); op_b = MW'(sum_t_r);   end
      OP_N_YY:  begin op_a = MW'(cnt_r);   op_b = MW'(sum_msq_r); end
      OP_Y_Y:   begin op_a = MW'(sum_m_r); op_b = MW'(sum_m_r);   end
      OP_A_A:   begin op_a = a_r;          op_b = a_r;            end
      OP_VX_VY: begin op_a = vx_r;         op_b = vy_r;           end
      default:  begin op_a = '0;           op_b = '0;             end
    endcase
  end

  assign abs_a = op_a[MW-1] ? MW'(-op_a) : MW'(op_a);
  assign abs_b = op_b[MW-1] ? MW'(-op_b) : MW'(op_b);

  // Serial multiplier: one multiplier bit a cycle.
  logic [PW-1:0] mc_r, macc_r, prod;
  logic [MW-1:0] mq_r;
  logic          mneg_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mc_r   <= PW'(abs_a);
      mq_r   <= abs_b;
      macc_r <= '0;
      mneg_r <= op_a[MW-1] ^ op_b[MW-1];
    end else if (cmd.mul_step) begin
      if (mq_r[0]) begin
        macc_r <= macc_r + mc_r;
      end
      mc_r <= mc_r << 1;
      mq_r <= mq_r >> 1;
    end
  end

  assign prod = mneg_r ? -macc_r : macc_r;

  // Divider registers.
  logic [DW-1:0] rem_r, t_r;
  logic [QW-1:0] q_r;

  // Store a finished product, then run the restoring divide.
  always_ff @(posedge clk) begin
    if (cmd.mul_store) begin
      unique case (cmd.op)
        OP_N_XY, OP_N_XX, OP_N_YY: pa_r <= prod[MW-1:0];
        OP_X_Y:   a_r  <= pa_r - prod[MW-1:0];
        OP_X_X:   vx_r <= pa_r - prod[MW-1:0];
        OP_Y_Y:   vy_r <= pa_r - prod[MW-1:0];
        OP_A_A:   rem_r <= DW'(prod) << RSQ_FRAC_BITS;
        OP_VX_VY: begin
          t_r <= DW'(prod) << (RSQ_FRAC_BITS + 1);
          q_r <= '0;
        end
        default: pa_r <= pa_r;
      endcase
    end else if (cmd.div_step) begin
      if (t_r <= rem_r) begin
        rem_r <= rem_r - t_r;
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
      t_r <= t_r >> 1;
    end
  end

  assign status.degen = (vx_r == '0) || (vy_r == '0);

  // Result registers.
  logic [QW-1:0] q_sat;
  assign q_sat = (q_r > QONE) ? QONE : q_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_chi_square <= sum_dsq_r;
      out_r_squared  <= status.degen ? '0 : RSQ_W'(q_sat);
      out_pair_count <= cnt_r;
      out_degenerate <= status.degen;
      out_overflowed <= ovf_r;
    end
  end

endmodule

// ----- hw/rtl/rsq_acc_checker.sv -----
// Port-level checker for the accumulator and its bind to the top level.
`include "residual_and_r_squared_accumulator_assert.svh"

module rsq_acc_checker #(
  parameter int MAX_ITEMS     = rsq_acc_pkg::MAX_ITEMS_DEF,
  parameter int RSQ_FRAC_BITS = rsq_acc_pkg::RSQ_FRAC_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [rsq_acc_pkg::CHI_W-1:0]       out_chi_square,
  input logic [rsq_acc_pkg::RSQ_W-1:0]       out_r_squared,
  input logic [rsq_acc_pkg::CNT_W-1:0]       out_pair_count,
  input logic                                out_degenerate
);
  import rsq_acc_pkg::*;

  // A stalled result beat holds.
  `RSQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_chi_square) && $stable(out_r_squared))
  // A degenerate result carries a zero coefficient.
  `RSQ_ASSERT_SAME(a_degen_zero, clk, rst_n, out_valid && out_degenerate, out_r_squared == '0)
  // The coefficient never passes one.
  `RSQ_ASSERT_SAME(a_rsq_max, clk, rst_n, out_valid, out_r_squared <= (RSQ_W'(1) << RSQ_FRAC_BITS))
  // A result counts at least one and at most MAX_ITEMS pairs.
  `RSQ_ASSERT_SAME(a_count_range, clk, rst_n, out_valid, (out_pair_count != '0) && (out_pair_count <= CNT_W'(MAX_ITEMS)))

endmodule

bind residual_and_r_squared_accumulator rsq_acc_checker #(
  .MAX_ITEMS    (MAX_ITEMS),
  .RSQ_FRAC_BITS(RSQ_FRAC_BITS)
) u_rsq_acc_checker (.*);

// ----- tb/tb_residual_and_r_squared_accumulator.sv -----
// Self-checking testbench for the residual and R squared accumulator.
module tb_residual_and_r_squared_accumulator;
  timeunit 1ns;
  timeprecision 1ps;
  import rsq_acc_pkg::*;

  localparam int LIMIT_CYCLES = 5000000;
  localparam int DRAIN_CYCLES = 700;
  localparam int RUN_CAP = MAX_ITEMS_DEF;

  typedef struct {
    logic [CHI_W-1:0] chi;
    logic [RSQ_W-1:0] rsq;
    logic [CNT_W-1:0] cnt;
    logic             degen;
    logic             ovf;
  } run_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [IN_W-1:0] in_target_value = '0;
  logic signed [IN_W-1:0] in_model_value = '0;
  logic                   in_last_item = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CHI_W-1:0]       out_chi_square;
  logic [RSQ_W-1:0]       out_r_squared;
  logic [CNT_W-1:0]       out_pair_count;
  logic                   out_degenerate;
  logic                   out_overflowed;

  // Running sums of the current run, mirrored from the block.
  int                run_count;
  longint            sum_x, sum_y, sum_xy, sum_xx, sum_yy;
  logic [CHI_W-1:0]  sum_dd;
  bit                run_ovf;

  run_result_t pending_results[$];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  int          recv_stall = 0;

  residual_and_r_squared_accumulator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_target_value(in_target_value), .in_model_value(in_model_value),
    .in_last_item(in_last_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_chi_square(out_chi_square), .out_r_squared(out_r_squared),
    .out_pair_count(out_pair_count), .out_degenerate(out_degenerate),
    .out_overflowed(out_overflowed)
  );

  always #6 clk = ~clk;

  // Bound the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void clear_sums();
    run_count = 0;
    sum_x = 0; sum_y = 0; sum_xy = 0; sum_xx = 0; sum_yy = 0;
    sum_dd = '0;
    run_ovf = 1'b0;
  endfunction

  // Accumulate one accepted pair; on the last pair, close the run.
  function automatic void accumulate_pair(logic signed [IN_W-1:0] tv,
                                          logic signed [IN_W-1:0] mv, logic last);
    longint x, y, d;
    logic signed [255:0] n, a, vx, vy;
    logic [255:0] num, den, quo;
    run_result_t r;
    x = tv;
    y = mv;
    if (run_count < RUN_CAP) begin
      d = y - x;
      run_count++;
      sum_x += x; sum_y += y; sum_xy += x * y;
      sum_xx += x * x; sum_yy += y * y;
      sum_dd = sum_dd + CHI_W'(d * d);
    end else begin
      run_ovf = 1'b1;
    end
    if (!last) return;
    n = 256'(run_count);
    a = n * 256'(sum_xy) - 256'(sum_x) * 256'(sum_y);
    vx = n * 256'(sum_xx) - 256'(sum_x) * 256'(sum_x);
    vy = n * 256'(sum_yy) - 256'(sum_y) * 256'(sum_y);
    r.degen = (vx == 0) || (vy == 0);
    r.rsq = '0;
    if (!r.degen) begin
      num = (a * a) << RSQ_FRAC_BITS_DEF;
      den = vx * vy;
      quo = num / den;
      if (quo > (256'd1 << RSQ_FRAC_BITS_DEF)) quo = 256'd1 << RSQ_FRAC_BITS_DEF;
      r.rsq = quo[RSQ_W-1:0];
    end
    r.chi = sum_dd;
    r.cnt = CNT_W'(run_count);
    r.ovf = run_ovf;
    pending_results.insert(pending_results.size(), r);
    clear_sums();
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Stall the receiver in random bursts.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= 1'b1;
      recv_stall <= 0;
    end else if (recv_stall > 0) begin
      out_ready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      recv_stall <= $urandom_range(0, 14);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    run_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result beat", 0, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_chi_square !== e.chi) report("chi_square", out_chi_square, e.chi);
        if (out_r_squared !== e.rsq) report("r_squared", out_r_squared, e.rsq);
        if (out_pair_count !== e.cnt) report("pair_count", out_pair_count, e.cnt);
        if (out_degenerate !== e.degen) report("degenerate", out_degenerate, e.degen);
        if (out_overflowed !== e.ovf) report("overflowed", out_overflowed, e.ovf);
      end
    end
  end

  // Send one pair, with an occasional idle burst first; valid stays up afterward.
  task automatic send_pair(logic signed [IN_W-1:0] tv, logic signed [IN_W-1:0] mv,
                           logic last);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_value <= tv;
    in_model_value <= mv;
    in_last_item <= last;
    do @(posedge clk); while (!in_ready);
    accumulate_pair(tv, mv, last);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic signed [IN_W-1:0] pick_sample();
    case ($urandom_range(0, 4))
      0: return IN_W'($urandom);
      1: return IN_W'($signed($urandom_range(0, 8191)) - 4096);
      2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return IN_W'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  // One run of random length with a random relation between target and model.
  task automatic random_run(int max_len);
    int len, mode;
    logic signed [IN_W-1:0] x, y, k;
    len = $urandom_range(1, max_len);
    mode = $urandom_range(0, 4);
    k = pick_sample();
    for (int i = 0; i < len; i++) begin
      x = pick_sample();
      case (mode)
        0: y = x;
        1: y = -x;
        2: y = x + IN_W'($signed($urandom_range(0, 255)) - 128);
        3: y = k;
        default: y = pick_sample();
      endcase
      send_pair(x, y, i == len - 1);
    end
  endtask

  task automatic test_extremes();
    send_pair(24'sh7FFFFF, 24'sh800000, 1'b0);
    send_pair(24'sh800000, 24'sh7FFFFF, 1'b0);
    send_pair(24'sh000000, 24'sh000001, 1'b1);
    send_pair(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
    send_pair(24'sh800000, 24'sh800000, 1'b1);
    send_pair(24'sh800000, 24'sh7FFFFF, 1'b0);
    send_pair(24'sh7FFFFF, 24'sh800000, 1'b1);
  endtask

  task automatic test_degenerate();
    // Single pair, then constant target, then constant model.
    send_pair(24'sh123456, 24'shFEDCBA, 1'b1);
    send_pair(24'sh001000, 24'sh000001, 1'b0);
    send_pair(24'sh001000, 24'sh002000, 1'b0);
    send_pair(24'sh001000, 24'sh7FFFFF, 1'b1);
    send_pair(24'sh000001, 24'sh800000, 1'b0);
    send_pair(24'sh7FFFFF, 24'sh800000, 1'b1);
  endtask

  task automatic test_correlation();
    send_pair(24'sh001000, 24'sh002000, 1'b0);
    send_pair(24'sh002000, 24'sh004000, 1'b0);
    send_pair(24'sh003000, 24'sh006000, 1'b1);
    send_pair(24'sh001000, -24'sh001000, 1'b0);
    send_pair(24'sh005000, -24'sh005000, 1'b1);
    send_pair(24'sh001000, 24'sh003000, 1'b0);
    send_pair(24'sh002000, 24'sh001000, 1'b0);
    send_pair(24'sh003000, 24'sh002000, 1'b1);
  endtask

  // Pairs past the cap are dropped; the last one still closes the run.
  task automatic test_overflow();
    for (int i = 0; i < RUN_CAP + 2; i++)
      send_pair(pick_sample(), pick_sample(), 1'b0);
    send_pair(24'sh7FFFFF, 24'sh800000, 1'b1);
  endtask

  task automatic test_random();
    for (int r = 0; r < 16; r++) begin
      random_run($urandom_range(0, 9) == 0 ? 64 : 12);
      if (r == 8) wait_drained();
    end
  endtask

  task automatic test_random_quiet();
    quiet = 1'b1;
    for (int r = 0; r < 8; r++) random_run(12);
  endtask

  initial begin
    clear_sums();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_degenerate();
    test_correlation();
    test_overflow();
    test_random();
    test_random_quiet();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
